@@ hw/rtl/ilir_pkg.sv @@
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and defaults for the indexed list: command and status codes,
// per-cell operation codes and the control bundle that drives each cell.
// ----------------------------------------------------------------------------
package ilir_pkg;

  localparam int unsigned CAPACITY_DEF      = 64;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_APPEND = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_RESIZE = 3'd5,
    CMD_EMPTY  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell of the row does in a cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE,
    OP_READ
  } cell_op_e;

  // Per-cell decode, worked out by the top level from the cell's slot number.
  typedef struct packed {
    cell_op_e op;
    logic     at_idx;     // slot == target index
    logic     above_idx;  // slot >  target index
    logic     le_len;     // slot <= entry count
    logic     lt_len_m1;  // slot + 1 < entry count
  } cell_ctrl_t;

endpackage

@@ hw/rtl/ilir_cell.sv @@
// ----------------------------------------------------------------------------
// ilir_cell
// One slot of the list: holds one element, takes its lower neighbor on
// insert and its upper neighbor on remove, and forms one stage of the read
// chain that walks a looked-up element down to slot zero.
// ----------------------------------------------------------------------------
module ilir_cell #(
  parameter int unsigned ELEMENT_WIDTH = ilir_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ilir_pkg::cell_ctrl_t     ctrl_i,
  input  logic [ELEMENT_WIDTH-1:0] wr_value_i,
  input  logic [ELEMENT_WIDTH-1:0] prev_elem_i,
  input  logic [ELEMENT_WIDTH-1:0] next_elem_i,
  input  logic [ELEMENT_WIDTH-1:0] next_rd_i,
  output logic [ELEMENT_WIDTH-1:0] elem_o,
  output logic [ELEMENT_WIDTH-1:0] rd_o
);

  logic [ELEMENT_WIDTH-1:0] elem_d, elem_q;
  logic [ELEMENT_WIDTH-1:0] rd_d, rd_q;

  always_comb begin
    elem_d = elem_q;
    unique case (ctrl_i.op)
      ilir_pkg::OP_WRITE: begin
        if (ctrl_i.at_idx) elem_d = wr_value_i;
      end
      ilir_pkg::OP_INSERT: begin
        if (ctrl_i.at_idx) begin
          elem_d = wr_value_i;
        end else if (ctrl_i.above_idx && ctrl_i.le_len) begin
          elem_d = prev_elem_i;
        end
      end
      ilir_pkg::OP_REMOVE: begin
        if ((ctrl_i.at_idx || ctrl_i.above_idx) && ctrl_i.lt_len_m1) elem_d = next_elem_i;
      end
      default: elem_d = elem_q;
    endcase
  end

  // Read chain: the target slot loads its element, every other slot passes
  // its upper neighbor down.
  assign rd_d = ctrl_i.at_idx ? elem_q : next_rd_i;

  // store contents are part of the reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= '0;
    end else begin
      elem_q <= elem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == ilir_pkg::OP_READ) rd_q <= rd_d;
  end

  assign elem_o = elem_q;
  assign rd_o   = rd_q;

endmodule

@@ hw/rtl/indexed_list_insert_remove.sv @@
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Bounded ordered list of CAPACITY elements held in a row of cells, with
// get / set / insert / append / remove / resize / empty commands.
// ----------------------------------------------------------------------------
// Every element lives in its own cell, and all cells shift in parallel, so
// set, insert, append, remove, resize, empty and every command that fails
// complete as soon as they are taken: a new command can follow in the next
// clock unless the spare result is taken. For a successful get, the target
// cell at the normalized index drops its word onto a read chain that moves
// it one cell per cycle down to cell zero, where the result register
// picks it up. No command is taken while a get walks the chain. A negative
// position counts back from the current length (for insert, -1 means after
// the last entry); an index out of range returns status RANGE, and a command
// that would pass CAPACITY returns status FULL, both leaving the list as it
// was. Reset zeroes every cell and the length at once, with no clearing
// pass. Resize up exposes whatever the uncovered cells last held; remove and
// empty leave the vacated cells as they are. A spare result register parts
// the two channels: a command transfers while one earlier result still
// waits, and outside a get, input stalls only once the spare is taken too.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
  parameter int unsigned CAPACITY      = ilir_pkg::CAPACITY_DEF,
  parameter int unsigned ELEMENT_WIDTH = ilir_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic signed [7:0]  position_i,
  input  logic [31:0]        element_value_i,
  input  logic [6:0]         new_length_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        read_value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         current_length_o
);

  // LW: entry count (0..CAPACITY), AW: cell address, IW: signed index math
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = ((LW > 8) ? LW : 8) + 2;
  localparam int unsigned EW = ELEMENT_WIDTH;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  // registers
  state_e      state_d, state_q;
  logic [LW-1:0] count_d, count_q;
  logic [LW-1:0] cnt_d, cnt_q;      // read chain steps left
  logic [AW-1:0] idx_d, idx_q;      // index held during a get
  logic        out_valid_d, out_valid_q;
  logic [31:0] read_value_d, read_value_q;
  logic [1:0]  status_d, status_q;
  logic [LW-1:0] length_d, length_q;
  // spare result, holds one result while the output register waits
  logic        spare_valid_d, spare_valid_q;
  logic [31:0] spare_value_d, spare_value_q;
  logic [1:0]  spare_status_d, spare_status_q;
  logic [LW-1:0] spare_length_d, spare_length_q;

  // result formed this cycle
  logic        res_valid;
  logic [31:0] res_value;
  logic [1:0]  res_status;
  logic [LW-1:0] res_length;

  // command decode
  ilir_pkg::cmd_e  cmd;
  ilir_pkg::cell_op_e op;
  logic            accept;
  logic            out_free;
  logic            is_ins;
  logic signed [IW-1:0] len_s, pos_s, extra_s, norm_s;
  logic            idx_ok;
  logic [AW-1:0]   idx_now, idx_sel;
  logic            full;
  logic            resize_big;
  logic [EW-1:0]   wr_value;

  // cell row
  ilir_pkg::cell_ctrl_t ctrl [CAPACITY];
  logic [EW-1:0] elem_w [CAPACITY];
  logic [EW-1:0] rd_w   [CAPACITY];

  // handshake: the output register is free when empty or being taken this
  // cycle; input waits only for the chain or a taken spare
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || spare_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  // index normalization: negative positions count back from the length,
  // insert gets one extra slot at the end
  assign cmd     = ilir_pkg::cmd_e'(command_i);
  assign is_ins  = (cmd == ilir_pkg::CMD_INSERT);
  assign len_s   = signed'(IW'(count_q));
  assign pos_s   = IW'(position_i);
  assign extra_s = signed'(IW'(is_ins));
  assign norm_s  = pos_s[IW-1] ? (len_s + pos_s + extra_s) : pos_s;
  assign idx_ok  = !norm_s[IW-1] && (norm_s < (len_s + extra_s));
  assign idx_now = norm_s[AW-1:0];

  assign full       = (count_q >= LW'(CAPACITY));
  assign resize_big = ({25'd0, new_length_i} > 32'(CAPACITY));
  assign wr_value   = EW'(element_value_i);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    op         = ilir_pkg::OP_HOLD;
    idx_sel    = idx_now;
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = ilir_pkg::ST_OK;
    res_length = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // every command but a good get answers right away
          res_valid = 1'b1;
          case (cmd)
            ilir_pkg::CMD_GET: begin
              if (idx_ok) begin
                res_valid = 1'b0;
                state_d   = ST_READ;
                idx_d     = idx_now;
                cnt_d     = LW'(idx_now) + LW'(1);
              end else begin
                res_status = ilir_pkg::ST_RANGE;
              end
            end
            ilir_pkg::CMD_SET: begin
              if (idx_ok) op = ilir_pkg::OP_WRITE;
              else res_status = ilir_pkg::ST_RANGE;
            end
            ilir_pkg::CMD_INSERT: begin
              if (!idx_ok) begin
                res_status = ilir_pkg::ST_RANGE;
              end else if (full) begin
                res_status = ilir_pkg::ST_FULL;
              end else begin
                op      = ilir_pkg::OP_INSERT;
                count_d = count_q + LW'(1);
              end
            end
            ilir_pkg::CMD_APPEND: begin
              idx_sel = count_q[AW-1:0];
              if (full) begin
                res_status = ilir_pkg::ST_FULL;
              end else begin
                op      = ilir_pkg::OP_WRITE;
                count_d = count_q + LW'(1);
              end
            end
            ilir_pkg::CMD_REMOVE: begin
              if (idx_ok) begin
                op      = ilir_pkg::OP_REMOVE;
                count_d = count_q - LW'(1);
              end else begin
                res_status = ilir_pkg::ST_RANGE;
              end
            end
            ilir_pkg::CMD_RESIZE: begin
              if (resize_big) res_status = ilir_pkg::ST_FULL;
              else count_d = LW'(new_length_i);
            end
            ilir_pkg::CMD_EMPTY: count_d = '0;
            default: ;  // unused code: no change
          endcase
          res_length = count_d;
        end
      end
      ST_READ: begin
        op      = ilir_pkg::OP_READ;
        idx_sel = idx_q;
        if (cnt_q != '0) begin
          cnt_d = cnt_q - LW'(1);
        end else begin
          // word has reached cell zero; the spare is empty here, since a get
          // only transfers while it is
          res_valid = 1'b1;
          res_value = 32'(rd_w[0]);
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output stage: the spare drains first, so results leave in order
  always_comb begin
    out_valid_d    = out_valid_q;
    read_value_d   = read_value_q;
    status_d       = status_q;
    length_d       = length_q;
    spare_valid_d  = spare_valid_q;
    spare_value_d  = spare_value_q;
    spare_status_d = spare_status_q;
    spare_length_d = spare_length_q;
    if (out_free) begin
      if (spare_valid_q) begin
        out_valid_d    = 1'b1;
        read_value_d   = spare_value_q;
        status_d       = spare_status_q;
        length_d       = spare_length_q;
        spare_valid_d  = res_valid;
        spare_value_d  = res_value;
        spare_status_d = res_status;
        spare_length_d = res_length;
      end else begin
        out_valid_d  = res_valid;
        read_value_d = res_value;
        status_d     = res_status;
        length_d     = res_length;
      end
    end else if (res_valid) begin
      spare_valid_d  = 1'b1;
      spare_value_d  = res_value;
      spare_status_d = res_status;
      spare_length_d = res_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
      spare_valid_q <= spare_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q          <= idx_d;
    read_value_q   <= read_value_d;
    status_q       <= status_d;
    length_q       <= length_d;
    spare_value_q  <= spare_value_d;
    spare_status_q <= spare_status_d;
    spare_length_q <= spare_length_d;
  end

  // row of cells; neighbors past either end read as zero
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [EW-1:0] prev_elem, next_elem, next_rd;

    assign ctrl[k].op        = op;
    assign ctrl[k].at_idx    = (AW'(k) == idx_sel);
    assign ctrl[k].above_idx = (AW'(k) > idx_sel);
    assign ctrl[k].le_len    = (LW'(k) <= count_q);
    assign ctrl[k].lt_len_m1 = (LW'(k + 1) < count_q);

    if (k == 0) begin : g_first
      assign prev_elem = '0;
    end else begin : g_mid
      assign prev_elem = elem_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign next_elem = '0;
      assign next_rd   = '0;
    end else begin : g_body
      assign next_elem = elem_w[k+1];
      assign next_rd   = rd_w[k+1];
    end

    ilir_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[k]),
      .wr_value_i (wr_value),
      .prev_elem_i(prev_elem),
      .next_elem_i(next_elem),
      .next_rd_i  (next_rd),
      .elem_o     (elem_w[k]),
      .rd_o       (rd_w[k])
    );
  end

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = read_value_q;
  assign status_o         = status_q;
  assign current_length_o = 7'(length_q);

  // length never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LW'(CAPACITY))
    else $error("entry count above capacity");

  // append to a list with room grows it by one
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == ilir_pkg::CMD_APPEND && !full |=> count_q == $past(count_q) + LW'(1))
    else $error("append did not grow the list");

  // a good get goes through the read chain and changes no length
  a_get_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == ilir_pkg::CMD_GET && idx_ok
      |=> state_q == ST_READ && !spare_valid_q && count_q == $past(count_q))
    else $error("get did not start a chain read");

endmodule

@@ tb/sv/tb_indexed_list_insert_remove.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove
// Self-checking bench for the bounded indexed list. Commands go in over the
// valid/stall channel and results come back over the second one. A local
// copy of the list predicts every result, and each result transfer is
// compared with the oldest pending prediction. Directed cases cover empty
// and full lists, edge positions and the unused opcode. Random phases then
// mix fill-heavy, drain-heavy and noisy traffic under bursty input and
// result back-pressure.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_remove;
  import ilir_pkg::*;

  localparam int unsigned LIST_DEPTH   = CAPACITY_DEF;
  localparam logic [2:0]  CMD_UNUSED   = 3'd7;   // not decoded by the block
  // A get at the deepest slot walks the whole read chain.
  localparam int          DRAIN_CYCLES = LIST_DEPTH + 20;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 1000000;

  typedef enum int {SNK_OPEN, SNK_RANDOM, SNK_PATTERN} snk_mode_e;

  typedef struct {
    logic [31:0] read_value;
    status_e     status;
    logic [6:0]  length;
  } list_result_t;

  // --------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall_o;
  logic [2:0]         cmd_drv    = '0;
  logic signed [7:0]  pos_drv    = '0;
  logic [31:0]        value_drv  = '0;
  logic [6:0]         nlen_drv   = '0;
  logic               out_valid_o;
  logic               out_stall  = 1'b0;
  logic [31:0]        read_value_o;
  logic [1:0]         status_o;
  logic [6:0]         current_length_o;

  indexed_list_insert_remove dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .command_i        (cmd_drv),
    .position_i       (pos_drv),
    .element_value_i  (value_drv),
    .new_length_i     (nlen_drv),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .read_value_o     (read_value_o),
    .status_o         (status_o),
    .current_length_o (current_length_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow list: its own copy of the element store and length, advanced once
  // per accepted command transfer.
  // --------------------------------------------------------------------------
  logic [31:0]  list_mem [LIST_DEPTH];
  int           list_len = 0;
  list_result_t due_results [$];   // predictions waiting for their transfer
  int           err_cnt   = 0;
  int           cycle_cnt = 0;

  // Sender pacing: bursts of random length, gaps bounded by src_gap_max.
  int           src_gap_max = 0;
  int           burst_left  = 0;

  // Receiver pacing, plus a one-shot long hold requested by a test.
  snk_mode_e    snk_mode  = SNK_OPEN;
  int           hold_req  = 0;
  int           hold_cnt  = 0;
  int           snk_phase = 0;
  logic         stall_next;
  list_result_t head_exp;

  // Map a signed position onto a slot; extra is 1 for insert (one slot past
  // the end is legal there, and -1 lands on it).
  function automatic bit list_norm(input int pos, input int extra, output int idx);
    int i;
    i = pos;
    if (i < 0) i = list_len + i + extra;
    idx = i;
    return (i >= 0) && (i < list_len + extra);
  endfunction

  function automatic list_result_t list_apply(input logic [2:0] cmd,
                                              input logic signed [7:0] pos,
                                              input logic [31:0] val,
                                              input logic [6:0] nlen);
    list_result_t r;
    int idx;
    int k;
    r.read_value = '0;
    r.status     = ST_OK;
    case (cmd)
      CMD_GET: begin
        if (list_norm(pos, 0, idx)) r.read_value = list_mem[idx];
        else r.status = ST_RANGE;
      end
      CMD_SET: begin
        if (list_norm(pos, 0, idx)) list_mem[idx] = val;
        else r.status = ST_RANGE;
      end
      CMD_INSERT: begin
        // index checked before capacity
        if (!list_norm(pos, 1, idx)) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (k = list_len; k > idx; k--) list_mem[k] = list_mem[k-1];
          list_mem[idx] = val;
          list_len++;
        end
      end
      CMD_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        // vacated top slot keeps its old word
        if (list_norm(pos, 0, idx)) begin
          for (k = idx; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      CMD_RESIZE: begin
        if (nlen > LIST_DEPTH) r.status = ST_FULL;
        else list_len = nlen;
      end
      CMD_EMPTY: list_len = 0;
      default: ;   // unused opcode: no effect, status OK
    endcase
    r.length = 7'(list_len);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Command sender. Valid stays high from one transfer to the next unless a
  // gap is due, so there is never a low/high pair on valid in one step.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic [2:0] cmd, input logic signed [7:0] pos,
                          input logic [31:0] val, input logic [6:0] nlen);
    int gap;
    gap = 0;
    if (src_gap_max > 0) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, src_gap_max);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd_drv   <= cmd;
    pos_drv   <= pos;
    value_drv <= val;
    nlen_drv  <= nlen;
    do @(posedge clk_i); while (in_stall_o);
    due_results.push_back(list_apply(cmd, pos, val, nlen));
  endtask

  // Drop valid, then hold off until every prediction has been matched and
  // the read chain has had time to empty.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: drives stall on its own pattern. A long hold requested
  // by a test is counted down here, independent of the sender.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      stall_next = 1'b1;
    end else begin
      case (snk_mode)
        SNK_RANDOM:  stall_next = ($urandom_range(0, 99) < 35);
        SNK_PATTERN: stall_next = ((snk_phase % 7) < 3);
        default:     stall_next = 1'b0;
      endcase
    end
    snk_phase++;
    out_stall <= stall_next;
  end

  // Result checker: one compare per accepted result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing pending: read_value %h status %0d length %0d",
               read_value_o, status_o, current_length_o);
        err_cnt++;
      end else begin
        head_exp = due_results.pop_front();
        if (read_value_o !== head_exp.read_value) begin
          $error("read_value: expected %h, got %h", head_exp.read_value, read_value_o);
          err_cnt++;
        end
        if (status_o !== head_exp.status) begin
          $error("status: expected %0d, got %0d", head_exp.status, status_o);
          err_cnt++;
        end
        if (current_length_o !== head_exp.length) begin
          $error("current_length: expected %0d, got %0d", head_exp.length,
                 current_length_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_indexed_list_insert_remove: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Random field helpers
  // --------------------------------------------------------------------------
  // Mostly a legal slot, in positive or negative form; some just past either
  // end; the rest any byte at all.
  function automatic logic signed [7:0] pick_position(input int extra);
    int span;
    int idx;
    int r;
    span = list_len + extra;
    r    = $urandom_range(0, 99);
    if (span == 0 || r < 12) return 8'($urandom_range(0, 255));
    if (r < 22) return $urandom_range(0, 1) ? 8'(span) : 8'(-span - 1);
    idx = $urandom_range(0, span - 1);
    return $urandom_range(0, 1) ? 8'(idx) : 8'(idx - span);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] pick_length();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(LIST_DEPTH + 1, 127));
    if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, 8));
    return 7'($urandom_range(0, LIST_DEPTH));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Fresh list: everything index-based fails, insert at -1 lands at slot 0.
  task automatic test_empty_list();
    src_gap_max = 2;
    snk_mode    = SNK_RANDOM;
    send_cmd(CMD_GET,    8'sd0,  32'h0, 7'd0);
    send_cmd(CMD_REMOVE, -8'sd1, 32'h0, 7'd0);
    send_cmd(CMD_INSERT, 8'sd1,  32'h1234_5678, 7'd0);
    send_cmd(CMD_INSERT, -8'sd1, 32'hFFFF_FFFF, 7'd0);
    send_cmd(CMD_UNUSED, 8'sh80, 32'hFFFF_FFFF, 7'h7F);
  endtask

  // Edge positions on a short list, including the byte extremes.
  task automatic test_edge_positions();
    send_cmd(CMD_APPEND, 8'sd0,   32'h0000_0000, 7'd0);
    send_cmd(CMD_INSERT, 8'sd0,   32'hA5A5_A5A5, 7'd0);
    send_cmd(CMD_INSERT, -8'sd4,  32'h0000_0001, 7'd0);  // -(len+1): slot 0
    send_cmd(CMD_INSERT, 8'sd5,   32'hDEAD_BEEF, 7'd0);  // one past the extra slot
    send_cmd(CMD_GET,    -8'sd1,  32'h0, 7'd0);
    send_cmd(CMD_GET,    -8'sd5,  32'h0, 7'd0);
    send_cmd(CMD_GET,    8'sd127, 32'h0, 7'd0);
    send_cmd(CMD_SET,    -8'sd1,  32'h8000_0001, 7'd0);
    send_cmd(CMD_SET,    8'sh80,  32'h7FFF_FFFE, 7'd0);
    send_cmd(CMD_REMOVE, 8'sd0,   32'h0, 7'd0);
  endtask

  // Full list, capacity errors, and stale words exposed by resize.
  task automatic test_capacity();
    snk_mode = SNK_PATTERN;
    send_cmd(CMD_RESIZE, 8'sd0,   32'h0, 7'(LIST_DEPTH));
    send_cmd(CMD_GET,    8'sd63,  32'h0, 7'd0);          // deepest slot
    send_cmd(CMD_GET,    -8'sd64, 32'h0, 7'd0);
    send_cmd(CMD_APPEND, 8'sd0,   32'h1111_1111, 7'd0);
    send_cmd(CMD_INSERT, -8'sd1,  32'h2222_2222, 7'd0);  // legal index, but full
    send_cmd(CMD_INSERT, 8'sd65,  32'h3333_3333, 7'd0);  // bad index wins over full
    send_cmd(CMD_RESIZE, 8'sd0,   32'h0, 7'(LIST_DEPTH + 1));
    send_cmd(CMD_RESIZE, 8'sd0,   32'h0, 7'h7F);
    send_cmd(CMD_EMPTY,  8'sd0,   32'h0, 7'd0);
    send_cmd(CMD_RESIZE, 8'sd0,   32'h0, 7'd5);          // old words come back
    send_cmd(CMD_GET,    8'sd4,   32'h0, 7'd0);
  endtask

  // Weighted random traffic. grow_w and shrink_w steer the list length; a
  // slice of pure noise puts every field through its whole range.
  task automatic test_random_mix(input int n, input int grow_w, input int shrink_w);
    int i;
    int r;
    logic [2:0] cmd;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom,
                 7'($urandom_range(0, 127)));
      end else begin
        r = $urandom_range(0, 40 + 2 * grow_w + shrink_w + 6 - 1);
        if (r < 22)                                   cmd = CMD_GET;
        else if (r < 40)                              cmd = CMD_SET;
        else if (r < 40 + grow_w)                     cmd = CMD_INSERT;
        else if (r < 40 + 2 * grow_w)                 cmd = CMD_APPEND;
        else if (r < 40 + 2 * grow_w + shrink_w)      cmd = CMD_REMOVE;
        else if (r < 40 + 2 * grow_w + shrink_w + 4)  cmd = CMD_RESIZE;
        else if (r < 40 + 2 * grow_w + shrink_w + 5)  cmd = CMD_EMPTY;
        else                                          cmd = CMD_UNUSED;
        send_cmd(cmd, pick_position(cmd == CMD_INSERT ? 1 : 0), pick_value(),
                 pick_length());
      end
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the result register and its spare fill and input stalls.
  task automatic test_result_holdoff();
    src_gap_max = 0;
    snk_mode    = SNK_OPEN;
    hold_req    = HOLD_CYCLES;
    test_random_mix(40, 15, 15);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < LIST_DEPTH; i++) list_mem[i] = '0;
    list_len = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_edge_positions();
    test_capacity();
    drain_results();

    // fill-heavy, bursty input, random back-pressure
    src_gap_max = 6;
    snk_mode    = SNK_RANDOM;
    test_random_mix(400, 25, 10);
    drain_results();

    // drain-heavy, no idling on either side
    src_gap_max = 0;
    snk_mode    = SNK_OPEN;
    test_random_mix(400, 5, 30);

    // balanced, short gaps, fixed stall pattern
    src_gap_max = 3;
    snk_mode    = SNK_PATTERN;
    test_random_mix(400, 15, 15);
    drain_results();

    test_result_holdoff();
    drain_results();

    // long gaps, random stalls, list mostly kept full
    src_gap_max = 8;
    snk_mode    = SNK_RANDOM;
    test_random_mix(500, 30, 12);
    drain_results();

    if (err_cnt == 0) begin
      $display("tb_indexed_list_insert_remove: clean");
    end else begin
      $display("tb_indexed_list_insert_remove: errors");
    end
    $finish;
  end

endmodule
